/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands used by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every edge outside reset
`define STL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// prop must never hold outside reset
`define STL_ASSERT_NEVER(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error(msg);

`endif

/* rtl/stl_pkg.sv */
// ----------------------------------------------------------------------------
// stl_pkg
// Types, token codes, character classes and keyword table for the lexer.
// ----------------------------------------------------------------------------
package stl_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_SLASH   = 3'd1,
    MODE_COMMENT = 3'd2,
    MODE_STRING  = 3'd3,
    MODE_NUMBER  = 3'd4,
    MODE_WORD    = 3'd5,
    MODE_HALT    = 3'd6
  } lex_mode_t;

  localparam logic [4:0] KIND_NUM    = 5'd0;
  localparam logic [4:0] KIND_STR    = 5'd1;
  localparam logic [4:0] KIND_ID     = 5'd2;
  localparam logic [4:0] KIND_INT    = 5'd3;
  localparam logic [4:0] KIND_FLOAT  = 5'd4;
  localparam logic [4:0] KIND_IF     = 5'd5;
  localparam logic [4:0] KIND_ELSE   = 5'd6;
  localparam logic [4:0] KIND_RETURN = 5'd7;
  localparam logic [4:0] KIND_WHILE  = 5'd8;
  localparam logic [4:0] KIND_FOR    = 5'd9;
  localparam logic [4:0] KIND_EQ     = 5'd10;
  localparam logic [4:0] KIND_PLUS   = 5'd11;
  localparam logic [4:0] KIND_MINUS  = 5'd12;
  localparam logic [4:0] KIND_STAR   = 5'd13;
  localparam logic [4:0] KIND_DIV    = 5'd14;
  localparam logic [4:0] KIND_LPAREN = 5'd15;
  localparam logic [4:0] KIND_RPAREN = 5'd16;
  localparam logic [4:0] KIND_LBRACE = 5'd17;
  localparam logic [4:0] KIND_RBRACE = 5'd18;
  localparam logic [4:0] KIND_SEMI   = 5'd19;
  localparam logic [4:0] KIND_GT     = 5'd20;
  localparam logic [4:0] KIND_EOF    = 5'd21;
  localparam logic [4:0] KIND_ERR    = 5'd22;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  localparam int KW_COUNT = 8;
  // last six bytes of a word, packed, oldest byte highest
  localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
    48'h000000696E74, 48'h00666C6F6174, 48'h737472696E67, 48'h000000006966,
    48'h0000656C7365, 48'h72657475726E, 48'h007768696C65, 48'h000000666F72
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd3, 3'd5, 3'd6, 3'd2, 3'd4, 3'd6, 3'd5, 3'd3
  };
  localparam logic [4:0] KW_KIND [KW_COUNT] = '{
    KIND_INT, KIND_FLOAT, KIND_STR, KIND_IF,
    KIND_ELSE, KIND_RETURN, KIND_WHILE, KIND_FOR
  };

  localparam int MAX_TOKENS  = 3;
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] kind;
  } op_hit_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic op_hit_t op_lookup(input logic [7:0] c);
    op_hit_t res;
    res.hit = 1'b1;
    unique case (c)
      CH_EQ:     res.kind = KIND_EQ;
      CH_PLUS:   res.kind = KIND_PLUS;
      CH_MINUS:  res.kind = KIND_MINUS;
      CH_STAR:   res.kind = KIND_STAR;
      CH_SLASH:  res.kind = KIND_DIV;
      CH_LPAREN: res.kind = KIND_LPAREN;
      CH_RPAREN: res.kind = KIND_RPAREN;
      CH_LBRACE: res.kind = KIND_LBRACE;
      CH_RBRACE: res.kind = KIND_RBRACE;
      CH_SEMI:   res.kind = KIND_SEMI;
      CH_GT:     res.kind = KIND_GT;
      default: begin
        res.hit  = 1'b0;
        res.kind = KIND_ERR;
      end
    endcase
    return res;
  endfunction

  function automatic logic [4:0] word_kind(input logic len_short, input logic [2:0] len3,
                                           input logic [47:0] kw_text);
    logic [4:0] kind;
    kind = KIND_ID;
    for (int i = 0; i < KW_COUNT; i++) begin
      if (len_short && (len3 == KW_LEN[i]) && (kw_text == KW_TEXT[i])) begin
        kind = KW_KIND[i];
      end
    end
    return kind;
  endfunction

endpackage

/* rtl/stl_front.sv */
// ----------------------------------------------------------------------------
// stl_front
// Scanner state machine: classifies each byte and builds a bundle of up to
// three tokens per item for the token queue.
// ----------------------------------------------------------------------------
module stl_front #(
  parameter int OFFSET_WIDTH = 24,
  parameter int LINE_WIDTH   = 20,
  localparam int TOK_W = 5 + 2 * OFFSET_WIDTH + LINE_WIDTH + 8,
  localparam int BUN_W = 2 + 3 * TOK_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             take,
  input  logic [7:0]       char_byte,
  input  logic             has_byte,
  input  logic             is_end,
  output logic             push,
  output logic [BUN_W-1:0] bundle
);
  import stl_pkg::*;

  typedef struct packed {
    logic [4:0]              kind;
    logic [OFFSET_WIDTH-1:0] start;
    logic [OFFSET_WIDTH-1:0] len;
    logic [LINE_WIDTH-1:0]   line;
    logic [7:0]              bad;
  } tok_t;

  typedef struct packed {
    tok_t [2:0] tok;
    logic [1:0] cnt;
  } bun_t;

  localparam logic [OFFSET_WIDTH-1:0] OFS_MAX = {OFFSET_WIDTH{1'b1}};
  localparam logic [OFFSET_WIDTH-1:0] OFS_ONE = OFFSET_WIDTH'(1);
  localparam logic [LINE_WIDTH-1:0]   LINE_MAX = {LINE_WIDTH{1'b1}};

  lex_mode_t               mode_r, mode_nxt, mode_a;
  logic [OFFSET_WIDTH-1:0] pos_r, pos_nxt, pos_a, pos_inc;
  logic [LINE_WIDTH-1:0]   line_r, line_nxt, line_a, line_inc;
  logic [OFFSET_WIDTH-1:0] tstart_r, tstart_nxt, ts_a;
  logic [47:0]             kwbuf_r, kwbuf_nxt, buf_a;

  logic    dig, alp, spc, nl, sl, qt;
  op_hit_t op;
  logic    do_idle, close_tok;
  logic    a_v, b_v, c_v, d_v, mid_v;
  logic [OFFSET_WIDTH-1:0] span_a, span_c;
  tok_t    tok_a, tok_b, tok_c, tok_d, tok_m;
  bun_t    bun;

  assign dig = is_digit(char_byte);
  assign alp = is_alpha(char_byte);
  assign spc = is_space(char_byte);
  assign nl  = (char_byte == CH_NL);
  assign sl  = (char_byte == CH_SLASH);
  assign qt  = (char_byte == CH_QUOTE);
  assign op  = op_lookup(char_byte);

  assign pos_inc  = (pos_r == OFS_MAX) ? pos_r : pos_r + 1'b1;
  assign line_inc = (line_r == LINE_MAX) ? line_r : line_r + 1'b1;

  always_comb begin
    do_idle   = 1'b0;
    close_tok = 1'b0;
    if (has_byte) begin
      unique case (mode_r)
        MODE_SLASH: begin
          do_idle   = !sl;
          close_tok = !sl;
        end
        MODE_COMMENT, MODE_HALT: begin
          do_idle = 1'b0;
        end
        MODE_STRING: begin
          close_tok = qt;
        end
        MODE_NUMBER: begin
          do_idle   = !dig;
          close_tok = !dig;
        end
        MODE_WORD: begin
          do_idle   = !(alp || dig);
          close_tok = !(alp || dig);
        end
        default: begin
          do_idle = 1'b1;
        end
      endcase
    end
  end

  // next state
  always_comb begin
    mode_a = mode_r;
    ts_a   = tstart_r;
    buf_a  = kwbuf_r;
    line_a = line_r;
    pos_a  = has_byte ? pos_inc : pos_r;
    if (has_byte) begin
      if ((mode_r == MODE_SLASH) && sl) begin
        mode_a = MODE_COMMENT;
      end
      if ((mode_r == MODE_COMMENT) && nl) begin
        mode_a = MODE_IDLE;
        line_a = line_inc;
      end
      if ((mode_r == MODE_STRING) && qt) begin
        mode_a = MODE_IDLE;
      end
      if ((mode_r == MODE_WORD) && (alp || dig)) begin
        buf_a = {kwbuf_r[39:0], char_byte};
      end
      if (do_idle) begin
        mode_a = MODE_IDLE;
        priority if (nl) begin
          line_a = line_inc;
        end else if (sl) begin
          mode_a = MODE_SLASH;
          ts_a   = pos_r;
        end else if (qt) begin
          mode_a = MODE_STRING;
          ts_a   = pos_inc;
        end else if (spc) begin
          mode_a = MODE_IDLE;
        end else if (dig) begin
          mode_a = MODE_NUMBER;
          ts_a   = pos_r;
        end else if (alp) begin
          mode_a = MODE_WORD;
          ts_a   = pos_r;
          buf_a  = {40'd0, char_byte};
        end else if (op.hit) begin
          mode_a = MODE_IDLE;
        end else begin
          mode_a = MODE_HALT;
        end
      end
    end
    if (is_end) begin
      mode_nxt   = MODE_IDLE;
      pos_nxt    = '0;
      line_nxt   = '0;
      tstart_nxt = '0;
      kwbuf_nxt  = '0;
    end else begin
      mode_nxt   = mode_a;
      pos_nxt    = pos_a;
      line_nxt   = line_a;
      tstart_nxt = ts_a;
      kwbuf_nxt  = buf_a;
    end
  end

  // token outputs
  assign span_a = (pos_r > tstart_r) ? pos_r - tstart_r : '0;
  assign span_c = (pos_a > ts_a) ? pos_a - ts_a : '0;

  always_comb begin
    tok_a.start = tstart_r;
    tok_a.line  = line_r;
    tok_a.bad   = 8'd0;
    tok_a.len   = span_a;
    unique case (mode_r)
      MODE_SLASH: begin
        tok_a.kind = KIND_DIV;
        tok_a.len  = OFS_ONE;
      end
      MODE_STRING: tok_a.kind = KIND_STR;
      MODE_WORD:
        tok_a.kind = word_kind(span_a[OFFSET_WIDTH-1:3] == '0, span_a[2:0], kwbuf_r);
      default: tok_a.kind = KIND_NUM;
    endcase

    tok_b.kind  = op.hit ? op.kind : KIND_ERR;
    tok_b.start = pos_r;
    tok_b.len   = OFS_ONE;
    tok_b.line  = line_r;
    tok_b.bad   = op.hit ? 8'd0 : char_byte;

    tok_c.start = ts_a;
    tok_c.line  = line_a;
    tok_c.bad   = 8'd0;
    tok_c.len   = span_c;
    unique case (mode_a)
      MODE_SLASH: begin
        tok_c.kind = KIND_DIV;
        tok_c.len  = OFS_ONE;
      end
      MODE_STRING: tok_c.kind = KIND_STR;
      MODE_WORD:
        tok_c.kind = word_kind(span_c[OFFSET_WIDTH-1:3] == '0, span_c[2:0], buf_a);
      default: tok_c.kind = KIND_NUM;
    endcase

    tok_d.kind  = KIND_EOF;
    tok_d.start = pos_a;
    tok_d.len   = '0;
    tok_d.line  = line_a;
    tok_d.bad   = 8'd0;
  end

  assign a_v = close_tok;
  assign b_v = do_idle && !nl && !sl && !qt && !spc && !dig && !alp;
  assign c_v = is_end && ((mode_a == MODE_SLASH) || (mode_a == MODE_STRING) ||
                          (mode_a == MODE_NUMBER) || (mode_a == MODE_WORD));
  assign d_v = is_end && (mode_a != MODE_HALT);
  // an operator or error leaves no pending token, so b and c never coexist
  assign mid_v = b_v || c_v;
  assign tok_m = b_v ? tok_b : tok_c;

  always_comb begin
    bun.cnt    = {1'b0, a_v} + {1'b0, mid_v} + {1'b0, d_v};
    bun.tok[0] = a_v ? tok_a : (mid_v ? tok_m : tok_d);
    bun.tok[1] = (a_v && mid_v) ? tok_m : tok_d;
    bun.tok[2] = tok_d;
  end

  assign bundle = bun;
  assign push   = take && (bun.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      pos_r    <= '0;
      line_r   <= '0;
      tstart_r <= '0;
      kwbuf_r  <= '0;
    end else if (take) begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      line_r   <= line_nxt;
      tstart_r <= tstart_nxt;
      kwbuf_r  <= kwbuf_nxt;
    end
  end

endmodule

/* rtl/stl_queue.sv */
// ----------------------------------------------------------------------------
// stl_queue
// Small register queue of token bundles between scanner and emitter.
// ----------------------------------------------------------------------------
module stl_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [WIDTH-1:0]     wr_data,
  input  logic                 pop,
  output logic [WIDTH-1:0]     rd_data,
  output stl_pkg::q_stat_t     stat
);
  import stl_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]      count_r, count_nxt;

  assign stat.full  = (count_r == (PW + 1)'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign rd_data    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* rtl/stl_back.sv */
// ----------------------------------------------------------------------------
// stl_back
// Token emitter: walks the head bundle one token per cycle, unless out_ready
// stalls it, into a registered output stage; flags each bundle's last token.
// ----------------------------------------------------------------------------
module stl_back #(
  parameter int OFFSET_WIDTH = 24,
  parameter int LINE_WIDTH   = 20,
  localparam int TOK_W = 5 + 2 * OFFSET_WIDTH + LINE_WIDTH + 8,
  localparam int BUN_W = 2 + 3 * TOK_W
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  stl_pkg::q_stat_t        q_stat,
  input  logic [BUN_W-1:0]        head,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [4:0]              token_kind,
  output logic [OFFSET_WIDTH-1:0] start_offset,
  output logic [OFFSET_WIDTH-1:0] token_length,
  output logic [LINE_WIDTH-1:0]   line_number,
  output logic [7:0]              bad_char,
  output logic                    last_of_run
);
  import stl_pkg::*;

  typedef struct packed {
    logic [4:0]              kind;
    logic [OFFSET_WIDTH-1:0] start;
    logic [OFFSET_WIDTH-1:0] len;
    logic [LINE_WIDTH-1:0]   line;
    logic [7:0]              bad;
  } tok_t;

  typedef struct packed {
    tok_t [2:0] tok;
    logic [1:0] cnt;
  } bun_t;

  bun_t       head_b;
  logic [1:0] sel_r, sel_nxt;
  logic       valid_r, valid_nxt;
  logic       last_r;
  tok_t       tok_r;
  logic       load, is_last;

  assign head_b  = head;
  assign load    = !q_stat.empty && (!valid_r || out_ready);
  assign is_last = ((sel_r + 2'd1) == head_b.cnt);
  assign pop     = load && is_last;

  always_comb begin
    sel_nxt   = sel_r;
    valid_nxt = valid_r;
    if (load) begin
      sel_nxt   = is_last ? 2'd0 : sel_r + 2'd1;
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      sel_r   <= sel_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tok_r  <= head_b.tok[sel_r];
      last_r <= is_last;
    end
  end

  assign out_valid    = valid_r;
  assign token_kind   = tok_r.kind;
  assign start_offset = tok_r.start;
  assign token_length = tok_r.len;
  assign line_number  = tok_r.line;
  assign bad_char     = tok_r.bad;
  assign last_of_run  = last_r;

endmodule

/* rtl/source_text_lexer.sv */
// ----------------------------------------------------------------------------
// source_text_lexer
// Streaming lexer: source bytes in, tokens out (kind, offset, length, line).
// ----------------------------------------------------------------------------
// Channel | Dir | tdata                                  | tuser      | tlast
// in_     | in  | char_byte                              | has_byte   | is_end
// out_    | out | start_offset, token_length, line, bad  | token_kind | last_of_run
//
// One source byte is accepted per cycle while the four-bundle token queue
// has room; a byte yields zero to three tokens.
// Tokens leave one per cycle from a registered output stage while out_tready
// is high, so a byte's tokens leave in turn; the queue absorbs bursts.
// A byte's first token passes through the queue and then the output register.
// Reset leaves the block ready; no clearing pass.
// Output stalls fill the queue and then deassert in_tready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module source_text_lexer #(
  parameter int OFFSET_WIDTH = 24,
  parameter int LINE_WIDTH   = 20,
  localparam int OUT_DW = ((2 * OFFSET_WIDTH + LINE_WIDTH + 8 + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] char_byte
  input  logic              in_tuser,   // [0] has_byte
  input  logic              in_tlast,   // is_end
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // start_offset, token_length, line_number,
                                        // bad_char, zero pad
  output logic [4:0]        out_tuser,  // [4:0] token_kind
  output logic              out_tlast   // last_of_run
);
  import stl_pkg::*;

  localparam int TOK_W = 5 + 2 * OFFSET_WIDTH + LINE_WIDTH + 8;
  localparam int BUN_W = 2 + 3 * TOK_W;

  logic                    take;
  logic                    q_push, q_pop;
  logic [BUN_W-1:0]        q_wdata, q_rdata;
  q_stat_t                 q_stat;
  logic [OFFSET_WIDTH-1:0] start_offset, token_length;
  logic [LINE_WIDTH-1:0]   line_number;
  logic [7:0]              bad_char;

  assign in_tready = !q_stat.full;
  assign take      = in_tvalid && in_tready;

  stl_front #(
    .OFFSET_WIDTH (OFFSET_WIDTH),
    .LINE_WIDTH   (LINE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .char_byte (in_tdata),
    .has_byte  (in_tuser),
    .is_end    (in_tlast),
    .push      (q_push),
    .bundle    (q_wdata)
  );

  stl_queue #(
    .WIDTH (BUN_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wdata),
    .pop     (q_pop),
    .rd_data (q_rdata),
    .stat    (q_stat)
  );

  stl_back #(
    .OFFSET_WIDTH (OFFSET_WIDTH),
    .LINE_WIDTH   (LINE_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_stat       (q_stat),
    .head         (q_rdata),
    .pop          (q_pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .token_kind   (out_tuser),
    .start_offset (start_offset),
    .token_length (token_length),
    .line_number  (line_number),
    .bad_char     (bad_char),
    .last_of_run  (out_tlast)
  );

  assign out_tdata = OUT_DW'({bad_char, line_number, token_length, start_offset});

  `STL_ASSERT(a_push_room, clk, rst_n, q_push |-> !q_stat.full, "bundle pushed into full queue")
  `STL_ASSERT(a_pop_data, clk, rst_n, q_pop |-> !q_stat.empty, "pop from empty queue")
  `STL_ASSERT_NEVER(a_kind_range, clk, rst_n, out_tvalid && (out_tuser > KIND_ERR), "bad kind")
  `STL_ASSERT(a_eof_last, clk, rst_n, (out_tvalid && (out_tuser == KIND_EOF)) |-> out_tlast, "EOF not last")

endmodule
